>>> src/acp_pkg.sv
// Shared widths, codes and timing constants for the address conflict probe engine.
package acp_pkg;

   // Payload widths
   localparam int REQ_TYPE_W = 2;
   localparam int TIME_W     = 64;
   localparam int RND_W      = 31;
   localparam int POLICY_W   = 2;
   localparam int OP_W       = 16;
   localparam int MAC_W      = 48;
   localparam int STATUS_W   = 2;
   localparam int SEND_W     = 2;
   localparam int EVENT_W    = 3;
   localparam int TACT_W     = 2;

   // Configuration
   localparam int ADDR_W     = 32;
   localparam int MULT_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MULT  = 1'd1;
   localparam logic [MULT_W-1:0]    MULT_RESET        = 16'd9000;

   // Engine parameters and timing units
   localparam int DEF_PROBE_COUNT    = 3;
   localparam int DEF_ANNOUNCE_COUNT = 3;
   localparam int DEF_RFC_MULTIPLIER = 9000;
   localparam int CNT_W       = 2;
   localparam int WAIT_UNIT   = 111;
   localparam int MIN_UNIT    = 111;
   localparam int MAX_UNIT    = 333;
   localparam int ANN_UNIT    = 222;
   localparam logic [TIME_W-1:0] DEFEND_GAP = 64'd10000000;
   // largest scaled delay or jitter span: 65535 * 222 fits in 24 bits
   localparam int DELAY_W     = 24;

   // Request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_START    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_TIMER    = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_PACKET   = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_ANNOUNCE = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_INVAL = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_UNEXP = 2'd2;

   // Packet to send
   localparam logic [SEND_W-1:0] SEND_NONE     = 2'd0;
   localparam logic [SEND_W-1:0] SEND_PROBE    = 2'd1;
   localparam logic [SEND_W-1:0] SEND_ANNOUNCE = 2'd2;

   // Raised events
   localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
   localparam logic [EVENT_W-1:0] EV_READY    = 3'd1;
   localparam logic [EVENT_W-1:0] EV_USED     = 3'd2;
   localparam logic [EVENT_W-1:0] EV_DEFENDED = 3'd3;
   localparam logic [EVENT_W-1:0] EV_CONFLICT = 3'd4;

   // Timer actions
   localparam logic [TACT_W-1:0] TMR_LEAVE  = 2'd0;
   localparam logic [TACT_W-1:0] TMR_ARM    = 2'd1;
   localparam logic [TACT_W-1:0] TMR_CANCEL = 2'd2;

   // Defence policies
   localparam logic [POLICY_W-1:0] POLICY_NEVER   = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_ONCE    = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_ALWAYS  = 2'd2;
   localparam logic [POLICY_W-1:0] POLICY_INVALID = 2'd3;

endpackage

>>> src/acp_if.sv
// Valid/ready channel interfaces for request and response transactions.
interface acp_req_if import acp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [TIME_W-1:0]     now_usec;
   logic                  owner_claim;
   logic                  tx_dropped;
   logic [RND_W-1:0]      random_value;
   logic [POLICY_W-1:0]   defend_policy;
   logic [OP_W-1:0]       arp_operation;
   logic [MAC_W-1:0]      sender_hw_address;

   modport source (
      output valid, req_type, now_usec, owner_claim, tx_dropped, random_value,
             defend_policy, arp_operation, sender_hw_address,
      input  ready
   );
   modport sink (
      input  valid, req_type, now_usec, owner_claim, tx_dropped, random_value,
             defend_policy, arp_operation, sender_hw_address,
      output ready
   );
endinterface

interface acp_rsp_if import acp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SEND_W-1:0]   send_kind;
   logic [EVENT_W-1:0]  event_kind;
   logic [OP_W-1:0]     event_operation;
   logic [MAC_W-1:0]    event_sender;
   logic [TACT_W-1:0]   timer_action;
   logic [TIME_W-1:0]   timer_deadline;

   modport source (
      output valid, status, send_kind, event_kind, event_operation, event_sender,
             timer_action, timer_deadline,
      input  ready
   );
   modport sink (
      input  valid, status, send_kind, event_kind, event_operation, event_sender,
             timer_action, timer_deadline,
      output ready
   );
endinterface

>>> src/acp_rem_unit.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module acp_rem_unit import acp_pkg::*; #(
   parameter int DIVIDEND_W = RND_W,
   parameter int DIVISOR_W  = DELAY_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_BITS = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
   localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(DIVIDEND_W - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [DIVIDEND_W-1:0] dvd_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic [DIVISOR_W-1:0]  rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      // remainder stays below the divisor, so the low bits hold it
      rem_in = (trial >= {1'b0, dvs_ff}) ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= LAST_BIT;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> src/address_conflict_probe_fsm.sv
// Top level: ARP address conflict detection engine with sequencer and jitter remainder unit.
// Path: a request is captured, decided in ST_DECIDE, passes ST_MOD_START and ST_MOD_WAIT (the
//   bit-serial remainder unit) when jitter applies, then ST_SUM and ST_FINISH; one request in flight at a time.
// A new request is taken only once the previous response has been loaded into the output register.
// A finished response waits in an output register while the next request is taken.
// Reset (synchronous, active high): phase idle, counters and defence state zero,
//   probe address 0, delay scale register 9000.
module address_conflict_probe_fsm import acp_pkg::*; #(
   parameter int PROBE_COUNT    = DEF_PROBE_COUNT,
   parameter int ANNOUNCE_COUNT = DEF_ANNOUNCE_COUNT,
   parameter int RFC_MULTIPLIER = DEF_RFC_MULTIPLIER
) (
   input  logic                  clock,
   input  logic                  reset,
   acp_req_if.sink               req_if,
   acp_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam logic [CNT_W-1:0]   PROBE_CNT = CNT_W'(PROBE_COUNT);
   localparam logic [CNT_W-1:0]   ANN_CNT   = CNT_W'(ANNOUNCE_COUNT);
   localparam logic [CNT_W-1:0]   CNT_SAT   = '1;
   localparam logic [DELAY_W-1:0] ANN_DELAY = DELAY_W'(RFC_MULTIPLIER * ANN_UNIT);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECIDE, ST_MOD_START, ST_MOD_WAIT, ST_SUM, ST_FINISH
   } seq_state_type;

   typedef enum logic [2:0] {
      PH_IDLE, PH_PROBING, PH_CONFIGURING, PH_ANNOUNCING, PH_FAILED
   } phase_type;

   seq_state_type state_ff, state_in;

   // engine state
   phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]      sent_ff, sent_in;
   logic [POLICY_W-1:0]   mode_ff, mode_in;
   logic [TIME_W-1:0]     last_def_ff, last_def_in;
   logic [ADDR_W-1:0]     probe_addr_ff;
   logic [MULT_W-1:0]     mult_ff;

   // captured request
   logic [REQ_TYPE_W-1:0] rq_type_ff;
   logic [TIME_W-1:0]     now_ff;
   logic                  hard_ff;
   logic                  dropped_ff;
   logic [RND_W-1:0]      rnd_ff;
   logic [POLICY_W-1:0]   policy_ff;
   logic [OP_W-1:0]       op_ff;
   logic [MAC_W-1:0]      mac_ff;

   // decision
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SEND_W-1:0]     send_ff, send_in;
   logic [EVENT_W-1:0]    ev_ff, ev_in;
   logic [OP_W-1:0]       eop_ff, eop_in;
   logic [MAC_W-1:0]      esnd_ff, esnd_in;
   logic [TACT_W-1:0]     tact_ff, tact_in;
   logic [DELAY_W-1:0]    delay_ff, delay_in;
   logic [DELAY_W-1:0]    span_ff, span_in;
   logic [DELAY_W:0]      extra_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   o_status_ff;
   logic [SEND_W-1:0]     o_send_ff;
   logic [EVENT_W-1:0]    o_ev_ff;
   logic [OP_W-1:0]       o_eop_ff;
   logic [MAC_W-1:0]      o_esnd_ff;
   logic [TACT_W-1:0]     o_tact_ff;
   logic [TIME_W-1:0]     o_deadline_ff;

   logic [DELAY_W-1:0]    mult_min;
   logic [DELAY_W-1:0]    mult_span;
   logic [DELAY_W-1:0]    mult_wait;
   logic [CNT_W-1:0]      cnt_next;
   logic                  limited;
   logic                  conflict;
   logic                  req_fire;
   logic                  load_rsp;
   logic                  rem_start;
   logic                  rem_done;
   logic [DELAY_W-1:0]    rem_val;

   assign req_fire  = req_if.valid && req_if.ready;
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_if.ready);
   assign rem_start = (state_ff == ST_MOD_START);

   acp_rem_unit #(
      .DIVIDEND_W (RND_W),
      .DIVISOR_W  (DELAY_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rnd_ff),
      .divisor   (span_ff),
      .done      (rem_done),
      .remainder (rem_val)
   );

   // event decision, evaluated in ST_DECIDE
   always_comb begin
      mult_wait = DELAY_W'(mult_ff * WAIT_UNIT);
      mult_min  = DELAY_W'(mult_ff * MIN_UNIT);
      mult_span = DELAY_W'(mult_ff * ANN_UNIT);
      limited   = now_ff < (last_def_ff + DEFEND_GAP);
      conflict  = 1'b0;
      cnt_next  = sent_ff;

      phase_in    = phase_ff;
      sent_in     = sent_ff;
      mode_in     = mode_ff;
      last_def_in = last_def_ff;
      status_in   = STAT_OK;
      send_in     = SEND_NONE;
      ev_in       = EV_NONE;
      eop_in      = '0;
      esnd_in     = '0;
      tact_in     = TMR_LEAVE;
      delay_in    = '0;
      span_in     = '0;

      unique case (rq_type_ff)
         REQ_START: begin
            if (probe_addr_ff == '0) begin
               status_in = STAT_INVAL;
            end else begin
               phase_in    = PH_PROBING;
               mode_in     = POLICY_NEVER;
               last_def_in = '0;
               tact_in     = TMR_ARM;
               if (mult_ff != '0) begin
                  sent_in = '0;
                  span_in = mult_wait;
               end else begin
                  sent_in = PROBE_CNT;
               end
            end
         end
         REQ_TIMER: begin
            if (phase_ff == PH_PROBING) begin
               if (sent_ff < PROBE_CNT) begin
                  send_in  = SEND_PROBE;
                  cnt_next = dropped_ff ? sent_ff : sent_ff + 1'b1;
                  sent_in  = cnt_next;
                  tact_in  = TMR_ARM;
                  if (cnt_next < PROBE_CNT) begin
                     delay_in = mult_min;
                     span_in  = mult_span;
                  end else begin
                     delay_in = mult_span;
                  end
               end else begin
                  ev_in    = EV_READY;
                  phase_in = PH_CONFIGURING;
               end
            end else if (phase_ff == PH_ANNOUNCING) begin
               send_in  = SEND_ANNOUNCE;
               cnt_next = (!dropped_ff && sent_ff != CNT_SAT) ? sent_ff + 1'b1 : sent_ff;
               sent_in  = cnt_next;
               if (cnt_next < ANN_CNT) begin
                  tact_in  = TMR_ARM;
                  delay_in = ANN_DELAY;
               end
            end else begin
               status_in = STAT_UNEXP;
            end
         end
         REQ_PACKET: begin
            if (phase_ff == PH_PROBING) begin
               ev_in    = EV_USED;
               eop_in   = op_ff;
               esnd_in  = mac_ff;
               tact_in  = TMR_CANCEL;
               phase_in = PH_FAILED;
            end else if (phase_ff == PH_CONFIGURING) begin
               status_in = STAT_OK;
            end else if (phase_ff == PH_ANNOUNCING) begin
               if (hard_ff) begin
                  if (mode_ff == POLICY_ONCE) begin
                     if (limited) begin
                        conflict = 1'b1;
                     end else begin
                        send_in = SEND_ANNOUNCE;
                        if (dropped_ff) begin
                           conflict = 1'b1;
                        end else begin
                           last_def_in = now_ff;
                           ev_in       = EV_DEFENDED;
                        end
                     end
                  end else if (mode_ff == POLICY_ALWAYS) begin
                     if (!limited) begin
                        send_in     = SEND_ANNOUNCE;
                        last_def_in = now_ff;
                     end
                     ev_in = EV_DEFENDED;
                  end else begin
                     conflict = 1'b1;
                  end
                  if (conflict) begin
                     ev_in    = EV_CONFLICT;
                     tact_in  = TMR_CANCEL;
                     phase_in = PH_FAILED;
                  end
                  eop_in  = op_ff;
                  esnd_in = mac_ff;
               end
            end else begin
               status_in = STAT_UNEXP;
            end
         end
         REQ_ANNOUNCE: begin
            if (phase_ff == PH_IDLE || phase_ff == PH_FAILED) begin
               status_in = STAT_UNEXP;
            end else if (policy_ff == POLICY_INVALID) begin
               status_in = STAT_INVAL;
            end else begin
               phase_in = PH_ANNOUNCING;
               mode_in  = policy_ff;
               sent_in  = '0;
               tact_in  = TMR_ARM;
            end
         end
         default: status_in = STAT_UNEXP;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE:      if (req_fire) state_in = ST_DECIDE;
         ST_DECIDE:    state_in = (span_in != '0) ? ST_MOD_START : ST_SUM;
         ST_MOD_START: state_in = ST_MOD_WAIT;
         ST_MOD_WAIT:  if (rem_done) state_in = ST_SUM;
         ST_SUM:       state_in = ST_FINISH;
         ST_FINISH: begin
            if (load_rsp) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         sent_ff       <= '0;
         mode_ff       <= POLICY_NEVER;
         last_def_ff   <= '0;
         probe_addr_ff <= '0;
         mult_ff       <= MULT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_DECIDE) begin
            phase_ff    <= phase_in;
            sent_ff     <= sent_in;
            mode_ff     <= mode_in;
            last_def_ff <= last_def_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_PROBE_ADDRESS: probe_addr_ff <= csr_wr_data[ADDR_W-1:0];
               CSR_TIMEOUT_MULT:  mult_ff       <= csr_wr_data[MULT_W-1:0];
               default:           ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rq_type_ff <= req_if.req_type;
         now_ff     <= req_if.now_usec;
         hard_ff    <= req_if.owner_claim;
         dropped_ff <= req_if.tx_dropped;
         rnd_ff     <= req_if.random_value;
         policy_ff  <= req_if.defend_policy;
         op_ff      <= req_if.arp_operation;
         mac_ff     <= req_if.sender_hw_address;
      end
      if (state_ff == ST_DECIDE) begin
         status_ff <= status_in;
         send_ff   <= send_in;
         ev_ff     <= ev_in;
         eop_ff    <= eop_in;
         esnd_ff   <= esnd_in;
         tact_ff   <= tact_in;
         delay_ff  <= delay_in;
         span_ff   <= span_in;
      end
      if (state_ff == ST_SUM) begin
         // jitter only when a span was set; the unit is skipped otherwise
         extra_ff <= {1'b0, delay_ff} + ((span_ff != '0) ? {1'b0, rem_val} : '0);
      end
      if (load_rsp) begin
         o_status_ff   <= status_ff;
         o_send_ff     <= send_ff;
         o_ev_ff       <= ev_ff;
         o_eop_ff      <= eop_ff;
         o_esnd_ff     <= esnd_ff;
         o_tact_ff     <= tact_ff;
         o_deadline_ff <= (tact_ff == TMR_ARM) ? now_ff + TIME_W'(extra_ff) : '0;
      end
   end

   assign req_if.ready           = (state_ff == ST_IDLE);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = o_status_ff;
   assign rsp_if.send_kind       = o_send_ff;
   assign rsp_if.event_kind      = o_ev_ff;
   assign rsp_if.event_operation = o_eop_ff;
   assign rsp_if.event_sender    = o_esnd_ff;
   assign rsp_if.timer_action    = o_tact_ff;
   assign rsp_if.timer_deadline  = o_deadline_ff;

   // remainder completes only while the sequencer waits for it
   a_rem_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      rem_done |-> state_ff == ST_MOD_WAIT)
      else $error("remainder done outside wait state");

   // a request transaction blocks further requests until its response is loaded
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready)
      else $error("request accepted while another is in flight");

   // error responses carry no event and no timer action
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_status_ff != STAT_OK |->
         o_ev_ff == EV_NONE && o_tact_ff == TMR_LEAVE && o_send_ff == SEND_NONE)
      else $error("error response with side effects");

endmodule
